### rtl/capr_pkg.sv
// shared types, constants and saturation helpers for the comb/allpass reverb
`default_nettype none

package capr_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int LINE_W     = 24;
    localparam int MIX_W      = 16;
    localparam int COMB_LEN_W = 12;
    localparam int AP_LEN_W   = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int NUM_LINES  = 4;
    localparam int NUM_STAGES = 2;

    localparam int COMB_DEPTH_DEF    = 2048;
    localparam int ALLPASS_DEPTH_DEF = 1024;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = LINE_W + 1;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int FRAC    = 15;
    localparam int WIDE_W  = PROD_W - FRAC + 1;

    localparam logic [MUL_B_W-1:0] DAMP_COEF = 17'd9830;
    localparam logic [MUL_B_W-1:0] FULL_MIX  = 17'd32768;
    localparam logic [MUL_B_W-1:0] FB_GAIN [NUM_LINES] =
        '{17'd27525, 17'd26870, 17'd26214, 17'd25559};
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 42'sd16384;

    localparam logic [MIX_W-1:0] BYPASS_BELOW = 16'd33;

    localparam logic signed [WIDE_W-1:0] LINE_MAX_W   = 28'sd8388607;
    localparam logic signed [WIDE_W-1:0] LINE_MIN_W   = -28'sd8388608;
    localparam logic signed [WIDE_W-1:0] SAMPLE_MAX_W = 28'sd32767;
    localparam logic signed [WIDE_W-1:0] SAMPLE_MIN_W = -28'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIX        = 3'd0,
        REG_COMB_LEN_0 = 3'd1,
        REG_COMB_LEN_1 = 3'd2,
        REG_COMB_LEN_2 = 3'd3,
        REG_COMB_LEN_3 = 3'd4,
        REG_AP_LEN_0   = 3'd5,
        REG_AP_LEN_1   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [MIX_W-1:0]                        mix;
        logic [NUM_LINES-1:0][COMB_LEN_W-1:0]    comb_len;
        logic [NUM_STAGES-1:0][AP_LEN_W-1:0]     ap_len;
    } capr_cfg_t;

    localparam capr_cfg_t CFG_RESET = '{
        mix:      16'd0,
        comb_len: {12'd1356, 12'd1277, 12'd1188, 12'd1116},
        ap_len:   {11'd441, 11'd556}
    };

    typedef struct packed {
        logic               en;
        logic               rnd;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_op_t;

    function automatic logic signed [LINE_W-1:0] sat_line(input logic signed [WIDE_W-1:0] v);
        logic signed [LINE_W-1:0] r;
        priority if (v > LINE_MAX_W)
        begin
            r = {1'b0, {(LINE_W-1){1'b1}}};
        end
        else if (v < LINE_MIN_W)
        begin
            r = {1'b1, {(LINE_W-1){1'b0}}};
        end
        else
        begin
            r = v[LINE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [WIDE_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        priority if (v > SAMPLE_MAX_W)
        begin
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else if (v < SAMPLE_MIN_W)
        begin
            r = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/capr_ram.sv
// generic single write port ram with registered read
`default_nettype none

module capr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
)
(
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/capr_mult.sv
// shared signed multiplier with optional rounding offset and registered product
`default_nettype none

module capr_mult
    import capr_pkg::*;
(
    input  wire                       clk,
    input  var mul_op_t               op,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [MUL_A_W-1:0] a_s;
    logic signed [MUL_B_W-1:0] b_s;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_reg;

    assign a_s = op.a;
    assign b_s = op.b;

    always_comb
    begin
        prod_next = a_s * b_s;
        if (op.rnd)
        begin
            prod_next = prod_next + ROUND_HALF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

### rtl/capr_cfg.sv
// configuration register file: mix and delay lengths
`default_nettype none

module capr_cfg
    import capr_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_write_enable,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_data,
    output capr_cfg_t            cfg
);

    capr_cfg_t cfg_reg;
    capr_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_enable)
        begin
            unique case (cfg_index)
                REG_MIX:        cfg_next.mix         = cfg_data[MIX_W-1:0];
                REG_COMB_LEN_0: cfg_next.comb_len[0] = cfg_data[COMB_LEN_W-1:0];
                REG_COMB_LEN_1: cfg_next.comb_len[1] = cfg_data[COMB_LEN_W-1:0];
                REG_COMB_LEN_2: cfg_next.comb_len[2] = cfg_data[COMB_LEN_W-1:0];
                REG_COMB_LEN_3: cfg_next.comb_len[3] = cfg_data[COMB_LEN_W-1:0];
                REG_AP_LEN_0:   cfg_next.ap_len[0]   = cfg_data[AP_LEN_W-1:0];
                REG_AP_LEN_1:   cfg_next.ap_len[1]   = cfg_data[AP_LEN_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/comb_allpass_reverb.sv
// comb/allpass reverb: sequencer, datapath and delay memories around one multiplier
// one multiplier, shared by the comb damping, comb feedback and mix steps; one sample at a time
// per sample: 5 steps per comb line, 1 to average, 2 per allpass stage, 3 for the mix and
// 1 idle step; a result still waiting holds the next one in the last mix step
// bypass (mix below 33): sample sent out from the bypass state, stalls there; no state change
// reset: async active low; then a clearing pass writes zero to both delay memories
`default_nettype none

module comb_allpass_reverb
    import capr_pkg::*;
#(
    parameter int COMB_DEPTH    = COMB_DEPTH_DEF,
    parameter int ALLPASS_DEPTH = ALLPASS_DEPTH_DEF
)
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        cfg_write_enable,
    input  wire [CFG_IDX_W-1:0]        cfg_index,
    input  wire [CFG_DATA_W-1:0]       cfg_data,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire signed [SAMPLE_W-1:0]  sample_in,
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic signed [SAMPLE_W-1:0] sample_out
);

    // the clearing pass walks the larger of the two memory depths and keeps in_ready low
    localparam int CPW       = $clog2(COMB_DEPTH);
    localparam int APW       = $clog2(ALLPASS_DEPTH);
    localparam int C_TOT     = NUM_LINES * COMB_DEPTH;
    localparam int A_TOT     = NUM_STAGES * ALLPASS_DEPTH;
    localparam int CAW       = $clog2(C_TOT);
    localparam int AAW       = $clog2(A_TOT);
    localparam int CLW       = ((CPW + 1) > COMB_LEN_W) ? (CPW + 1) : COMB_LEN_W;
    localparam int ALW       = ((APW + 1) > AP_LEN_W) ? (APW + 1) : AP_LEN_W;
    localparam int CLR_DEPTH = (C_TOT > A_TOT) ? C_TOT : A_TOT;
    localparam int CLRW      = $clog2(CLR_DEPTH);
    localparam int LIDX_W    = $clog2(NUM_LINES);
    localparam int SIDX_W    = $clog2(NUM_STAGES);
    localparam int SUM_W     = LINE_W + LIDX_W;

    localparam logic [CAW-1:0]    C_STEP   = CAW'(COMB_DEPTH);
    localparam logic [AAW-1:0]    A_STEP   = AAW'(ALLPASS_DEPTH);
    localparam logic [CLW-1:0]    C_MAXLEN = CLW'(COMB_DEPTH);
    localparam logic [ALW-1:0]    A_MAXLEN = ALW'(ALLPASS_DEPTH);
    localparam logic [CLRW-1:0]   CLR_LAST = CLRW'(CLR_DEPTH - 1);
    localparam logic [CLRW:0]     CLR_C    = (CLRW + 1)'(C_TOT);
    localparam logic [CLRW:0]     CLR_A    = (CLRW + 1)'(A_TOT);
    localparam logic [LIDX_W-1:0] LAST_LN  = LIDX_W'(NUM_LINES - 1);
    localparam logic [SIDX_W-1:0] LAST_ST  = SIDX_W'(NUM_STAGES - 1);

    typedef enum logic [13:0] {
        S_CLEAR   = 14'h0001,
        S_IDLE    = 14'h0002,
        S_BYPASS  = 14'h0004,
        S_C_LOAD  = 14'h0008,
        S_C_DAMP  = 14'h0010,
        S_C_FILT  = 14'h0020,
        S_C_FB    = 14'h0040,
        S_C_WRITE = 14'h0080,
        S_AVG     = 14'h0100,
        S_A_LOAD  = 14'h0200,
        S_A_WRITE = 14'h0400,
        S_M_DRY   = 14'h0800,
        S_M_WET   = 14'h1000,
        S_M_SUM   = 14'h2000
    } state_t;

    capr_cfg_t cfg;
    mul_op_t   mul_op;
    logic signed [PROD_W-1:0] prod;

    state_t state_reg, state_next;
    logic [LIDX_W-1:0] line_reg, line_next;
    logic [SIDX_W-1:0] stage_reg, stage_next;
    logic [CLRW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [CPW-1:0]    cptr_reg [NUM_LINES];
    logic [CPW-1:0]    cptr_next [NUM_LINES];
    logic [APW-1:0]    aptr_reg [NUM_STAGES];
    logic [APW-1:0]    aptr_next [NUM_STAGES];
    logic signed [LINE_W-1:0] damp_reg [NUM_LINES];
    logic signed [LINE_W-1:0] damp_next [NUM_LINES];

    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic signed [LINE_W-1:0]   d_reg, d_next;
    logic signed [LINE_W:0]     diff_reg, diff_next;
    logic signed [LINE_W-1:0]   f_reg, f_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [LINE_W-1:0]   wet_reg, wet_next;
    logic signed [PROD_W-1:0]   acc_reg, acc_next;
    logic signed [SAMPLE_W-1:0] sample_out_reg, sample_out_next;

    // memory ports
    logic              c_we, a_we;
    logic [CAW-1:0]    c_waddr, c_raddr;
    logic [AAW-1:0]    a_waddr, a_raddr;
    logic [LINE_W-1:0] c_wdata, a_wdata, c_rdata, a_rdata;

    // datapath values
    logic signed [LINE_W-1:0]       c_rdata_s, a_rdata_s;
    logic signed [PROD_W-FRAC-1:0]  prod_q;
    logic signed [LINE_W-1:0]       f_val, c_fb_val, a_store_val, a_out_val, avg_val;
    logic signed [LINE_W:0]         d_inc;
    logic signed [LINE_W-1:0]       d_half;
    logic signed [SUM_W:0]          sum_rnd;
    logic signed [SUM_W-2:0]        avg_raw;
    logic signed [PROD_W:0]         mix_sum;
    logic signed [WIDE_W-1:0]       mix_q;
    logic signed [SAMPLE_W-1:0]     y_val;

    logic [LIDX_W-1:0]  line_rd;
    logic [CPW-1:0]     cptr_rd;
    logic [SIDX_W-1:0]  stage_rd;
    logic [APW-1:0]     aptr_rd;
    logic [COMB_LEN_W-1:0] c_len_raw;
    logic [AP_LEN_W-1:0]   a_len_raw;
    logic [CLW-1:0]     c_len_eff, c_ptr_inc;
    logic [ALW-1:0]     a_len_eff, a_ptr_inc;
    logic [CPW-1:0]     c_adv;
    logic [APW-1:0]     a_adv;
    logic [MIX_W:0]     m_eff;
    logic               bypass;

    capr_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cfg              (cfg)
    );

    capr_mult u_mult (
        .clk  (clk),
        .op   (mul_op),
        .prod (prod)
    );

    capr_ram #(
        .WIDTH (LINE_W),
        .DEPTH (C_TOT)
    ) u_comb_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    capr_ram #(
        .WIDTH (LINE_W),
        .DEPTH (A_TOT)
    ) u_ap_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    // current line and stage always sit at index 0, the pointer arrays rotate
    assign line_rd  = (state_reg == S_C_WRITE) ? line_reg + LIDX_W'(1) : line_reg;
    assign cptr_rd  = (state_reg == S_C_WRITE) ? cptr_reg[1] : cptr_reg[0];
    assign stage_rd = (state_reg == S_A_WRITE) ? stage_reg + SIDX_W'(1) : stage_reg;
    assign aptr_rd  = (state_reg == S_A_WRITE) ? aptr_reg[NUM_STAGES - 1] : aptr_reg[0];
    assign c_raddr  = CAW'(line_rd) * C_STEP + CAW'(cptr_rd);
    assign a_raddr  = AAW'(stage_rd) * A_STEP + AAW'(aptr_rd);

    assign c_rdata_s = c_rdata;
    assign a_rdata_s = a_rdata;
    assign prod_q    = prod[PROD_W-1:FRAC];

    // effective lengths and pointer advance
    assign c_len_raw = cfg.comb_len[line_reg];
    assign a_len_raw = cfg.ap_len[stage_reg];
    assign c_len_eff = (c_len_raw == '0) ? CLW'(1) :
                       ((CLW'(c_len_raw) > C_MAXLEN) ? C_MAXLEN : CLW'(c_len_raw));
    assign a_len_eff = (a_len_raw == '0) ? ALW'(1) :
                       ((ALW'(a_len_raw) > A_MAXLEN) ? A_MAXLEN : ALW'(a_len_raw));
    assign c_ptr_inc = CLW'(cptr_reg[0]) + CLW'(1);
    assign a_ptr_inc = ALW'(aptr_reg[0]) + ALW'(1);
    assign c_adv     = (c_ptr_inc >= c_len_eff) ? '0 : c_ptr_inc[CPW-1:0];
    assign a_adv     = (a_ptr_inc >= a_len_eff) ? '0 : a_ptr_inc[APW-1:0];

    assign bypass = cfg.mix < BYPASS_BELOW;
    assign m_eff  = ({1'b0, cfg.mix} > FULL_MIX) ? FULL_MIX : {1'b0, cfg.mix};

    // arithmetic around the shared product
    assign f_val    = sat_line(WIDE_W'(d_reg) + WIDE_W'(prod_q));
    assign c_fb_val = sat_line(WIDE_W'(x_reg) + WIDE_W'(prod_q));
    assign sum_rnd  = (SUM_W + 1)'(sum_reg) + (SUM_W + 1)'(2);
    assign avg_raw  = sum_rnd[SUM_W:LIDX_W];
    assign avg_val  = sat_line(WIDE_W'(avg_raw));
    // gain 0.5 with round half up is (d + 1) >> 1
    assign d_inc       = (LINE_W + 1)'(d_reg) + (LINE_W + 1)'(1);
    assign d_half      = d_inc[LINE_W:1];
    assign a_store_val = sat_line(WIDE_W'(wet_reg) + WIDE_W'(d_half));
    assign a_out_val   = sat_line(WIDE_W'(d_reg) - WIDE_W'(wet_reg));
    assign mix_sum     = (PROD_W + 1)'(acc_reg) + (PROD_W + 1)'(prod);
    assign mix_q       = mix_sum[PROD_W:FRAC];
    assign y_val       = sat_sample(mix_q);

    always_comb
    begin
        state_next      = state_reg;
        line_next       = line_reg;
        stage_next      = stage_reg;
        clr_cnt_next    = clr_cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cptr_next       = cptr_reg;
        aptr_next       = aptr_reg;
        damp_next       = damp_reg;
        x_next          = x_reg;
        d_next          = d_reg;
        diff_next       = diff_reg;
        f_next          = f_reg;
        sum_next        = sum_reg;
        wet_next        = wet_reg;
        acc_next        = acc_reg;
        sample_out_next = sample_out_reg;
        c_we            = 1'b0;
        c_waddr         = CAW'(line_reg) * C_STEP + CAW'(cptr_reg[0]);
        c_wdata         = c_fb_val;
        a_we            = 1'b0;
        a_waddr         = AAW'(stage_reg) * A_STEP + AAW'(aptr_reg[0]);
        a_wdata         = a_store_val;
        mul_op          = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                c_we         = ({1'b0, clr_cnt_reg} < CLR_C);
                c_waddr      = clr_cnt_reg[CAW-1:0];
                c_wdata      = '0;
                a_we         = ({1'b0, clr_cnt_reg} < CLR_A);
                a_waddr      = clr_cnt_reg[AAW-1:0];
                a_wdata      = '0;
                clr_cnt_next = clr_cnt_reg + CLRW'(1);
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = sample_in;
                    sum_next   = '0;
                    state_next = bypass ? S_BYPASS : S_C_LOAD;
                end
            end
            S_BYPASS:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    sample_out_next = x_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_C_LOAD:
            begin
                d_next     = c_rdata_s;
                diff_next  = (LINE_W + 1)'(damp_reg[0]) - (LINE_W + 1)'(c_rdata_s);
                state_next = S_C_DAMP;
            end
            S_C_DAMP:
            begin
                mul_op.en  = 1'b1;
                mul_op.rnd = 1'b1;
                mul_op.a   = MUL_A_W'(diff_reg);
                mul_op.b   = DAMP_COEF;
                state_next = S_C_FILT;
            end
            S_C_FILT:
            begin
                f_next       = f_val;
                damp_next[0] = f_val;
                sum_next     = sum_reg + SUM_W'(f_val);
                state_next   = S_C_FB;
            end
            S_C_FB:
            begin
                mul_op.en  = 1'b1;
                mul_op.rnd = 1'b1;
                mul_op.a   = MUL_A_W'(f_reg);
                mul_op.b   = FB_GAIN[line_reg];
                state_next = S_C_WRITE;
            end
            S_C_WRITE:
            begin
                c_we = 1'b1;
                for (int k = 0; k < NUM_LINES - 1; k++)
                begin
                    cptr_next[k] = cptr_reg[k + 1];
                    damp_next[k] = damp_reg[k + 1];
                end
                cptr_next[NUM_LINES - 1] = c_adv;
                damp_next[NUM_LINES - 1] = damp_reg[0];
                line_next = line_reg + LIDX_W'(1);
                state_next = (line_reg == LAST_LN) ? S_AVG : S_C_LOAD;
            end
            S_AVG:
            begin
                wet_next   = avg_val;
                state_next = S_A_LOAD;
            end
            S_A_LOAD:
            begin
                d_next     = a_rdata_s;
                state_next = S_A_WRITE;
            end
            S_A_WRITE:
            begin
                a_we     = 1'b1;
                wet_next = a_out_val;
                for (int k = 0; k < NUM_STAGES - 1; k++)
                begin
                    aptr_next[k] = aptr_reg[k + 1];
                end
                aptr_next[NUM_STAGES - 1] = a_adv;
                stage_next = stage_reg + SIDX_W'(1);
                state_next = (stage_reg == LAST_ST) ? S_M_DRY : S_A_LOAD;
            end
            S_M_DRY:
            begin
                mul_op.en  = 1'b1;
                mul_op.a   = MUL_A_W'(x_reg);
                mul_op.b   = FULL_MIX - m_eff;
                state_next = S_M_WET;
            end
            S_M_WET:
            begin
                acc_next   = prod;
                mul_op.en  = 1'b1;
                mul_op.rnd = 1'b1;
                mul_op.a   = MUL_A_W'(wet_reg);
                mul_op.b   = m_eff;
                state_next = S_M_SUM;
            end
            S_M_SUM:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    sample_out_next = y_val;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            line_reg      <= '0;
            stage_reg     <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_LINES; k++)
            begin
                cptr_reg[k] <= '0;
                damp_reg[k] <= '0;
            end
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                aptr_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            line_reg      <= line_next;
            stage_reg     <= stage_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            cptr_reg      <= cptr_next;
            damp_reg      <= damp_next;
            aptr_reg      <= aptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        d_reg          <= d_next;
        diff_reg       <= diff_next;
        f_reg          <= f_next;
        sum_reg        <= sum_next;
        wet_reg        <= wet_next;
        acc_reg        <= acc_next;
        sample_out_reg <= sample_out_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

endmodule

`default_nettype wire

### rtl/capr_checker.sv
// port-level checker for the reverb top level, attached by bind
`default_nettype none

module capr_checker
    import capr_pkg::*;
(
    input wire                        clk,
    input wire                        rst_n,
    input wire                        cfg_write_enable,
    input wire [CFG_IDX_W-1:0]        cfg_index,
    input wire [CFG_DATA_W-1:0]       cfg_data,
    input wire                        in_valid,
    input wire                        in_ready,
    input wire signed [SAMPLE_W-1:0]  sample_in,
    input wire                        out_valid,
    input wire                        out_ready,
    input wire signed [SAMPLE_W-1:0]  sample_out
);

    logic [MIX_W-1:0] mix_seen_reg;

    // shadow of the mix register as written through the port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_seen_reg <= CFG_RESET.mix;
        end
        else if (cfg_write_enable && (cfg_index == REG_MIX))
        begin
            mix_seen_reg <= cfg_data[MIX_W-1:0];
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(sample_out)))
        else $error("result changed or dropped while stalled");

    // one sample at a time: no new transfer right after one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after an input transfer");

    // a bypassed sample with no result pending comes out unchanged
    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid && (mix_seen_reg < BYPASS_BELOW))
        |-> ##2 (out_valid && (sample_out == $past(sample_in, 2))))
        else $error("bypass sample not passed through");

    // a new result only appears while the block was busy with an item
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while block was idle");

endmodule

bind comb_allpass_reverb capr_checker u_capr_checker (.*);

`default_nettype wire
